[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define BPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bps_pkg.sv]
// Package with the types and constants of the bit packer with byte stuffing.
`default_nettype none

package bps_pkg;

	// Field widths.
	localparam int unsigned BitsW  = 16;
	localparam int unsigned CountW = 5;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned PendW  = 7;
	localparam int unsigned PcntW  = 3;
	// Work accumulator: seven pending bits plus up to 24 new bits.
	localparam int unsigned AccW   = 31;
	localparam int unsigned WidthW = 5;

	// Stream packing widths.
	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 8;

	// Largest number of bits one put may append.
	localparam logic [CountW-1:0] MaxCount = 5'd24;
	// A byte of all ones is followed by a stuffed zero byte.
	localparam logic [ByteW-1:0] StuffMark = 8'hFF;
	localparam logic [ByteW-1:0] StuffByte = 8'h00;

	// Item kinds carried on the input side-band.
	localparam logic OpPut   = 1'b0;
	localparam logic OpFlush = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // take the input word into the accumulator
		logic push_data;   // send the top byte of the accumulator
		logic push_stuff;  // send the stuffed zero byte
	} bps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic have_byte;   // at least eight bits remain in the accumulator
		logic is_ff;       // the top byte is the stuffing mark
		logic last_byte;   // fewer than sixteen bits remain
		logic slot_free;   // the output register can take a word this cycle
	} bps_status_t;

endpackage

`default_nettype wire

[rtl/core/bit_packer_byte_stuffing.sv]
// Top level of the bit packer with byte stuffing.
// Each input word either appends the low bit_count bits of bits (count saturated at 24,
// most significant bit first) or, with tuser set, flushes the pending bits padded with
// zeros to a byte. Every complete byte leaves on the output stream; a 0xFF byte is
// always followed by a stuffed 0x00 byte, and tlast marks the final byte caused by
// an input word. One word is processed at a time: the word is accepted in the idle
// state, then the output register is loaded with one byte per cycle while the output
// side does not stall, giving B output bytes (0 to 5) per item. The byte sequencer and
// the single output register set this pace.
`default_nettype none

module bit_packer_byte_stuffing
	import bps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InDataW-1:0]  s_tdata,   // [15:0] bits, [20:16] bit_count, zero pad
	input  wire logic                s_tuser,   // op: 0 append, 1 flush
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata,   // [7:0] out_byte
	output logic                     m_tlast
);

	bps_cmd_t    cmd;
	bps_status_t status;

	// Controller.
	bps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	bps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_op     (s_tuser),
		.in_bits   (s_tdata[BitsW-1:0]),
		.in_count  (s_tdata[BitsW+CountW-1:BitsW]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

[rtl/core/bps_ctrl.sv]
// Controller state machine of the bit packer: accepts items and sequences byte output.
`default_nettype none

module bps_ctrl
	import bps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire bps_status_t status,
	output bps_cmd_t         cmd
);

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StEmit  = 2'd1;
	localparam logic [1:0] StStuff = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == StIdle);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			StIdle: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = StEmit;
				end
			end
			StEmit: begin
				if (!status.have_byte) begin
					state_d = StIdle;
				end else if (status.slot_free) begin
					cmd.push_data = 1'b1;
					if (status.is_ff) begin
						state_d = StStuff;
					end else if (status.last_byte) begin
						state_d = StIdle;
					end
				end
			end
			StStuff: begin
				if (status.slot_free) begin
					cmd.push_stuff = 1'b1;
					state_d = status.last_byte ? StIdle : StEmit;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/bps_dp.sv]
// Datapath of the bit packer: pending bit store, accumulator and output register.
`default_nettype none

module bps_dp
	import bps_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bps_cmd_t          cmd,
	output bps_status_t            status,
	input  wire logic              in_op,
	input  wire logic [BitsW-1:0]  in_bits,
	input  wire logic [CountW-1:0] in_count,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ByteW-1:0]       out_byte,
	output logic                   out_last
);

	logic [PendW-1:0]  pend_q;
	logic [PcntW-1:0]  pcnt_q;
	logic [AccW-1:0]   acc_q;
	logic [WidthW-1:0] width_q;
	logic              ovalid_q;
	logic [ByteW-1:0]  obyte_q;
	logic              olast_q;

	logic [CountW-1:0] n_sat;
	logic [AccW-1:0]   put_acc;
	logic [WidthW-1:0] put_width;
	logic [PendW-1:0]  put_pend;
	logic [ByteW-1:0]  flush_byte;
	logic [WidthW-1:0] rem_width;
	logic [ByteW-1:0]  top_byte;
	logic [AccW-1:0]   top_shift;

	// Append: shift the pending bits up and merge the masked new value.
	always_comb begin
		n_sat = (in_count > MaxCount) ? MaxCount : in_count;
		put_acc = ({{(AccW-PendW){1'b0}}, pend_q} << n_sat)
			| ({{(AccW-BitsW){1'b0}}, in_bits} & ~({AccW{1'b1}} << n_sat));
		put_width = {{(WidthW-PcntW){1'b0}}, pcnt_q} + n_sat;
		put_pend = put_acc[PendW-1:0] & ~({PendW{1'b1}} << put_width[PcntW-1:0]);
	end

	// Flush: left-align the pending bits in a byte and pad with zeros.
	assign flush_byte = ByteW'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));

	// Top byte of the remaining bits.
	always_comb begin
		rem_width = width_q - WidthW'(ByteW);
		top_shift = acc_q >> rem_width;
		top_byte = top_shift[ByteW-1:0];
	end

	assign status.have_byte = (width_q >= WidthW'(ByteW));
	assign status.is_ff     = (top_byte == StuffMark);
	assign status.last_byte = (width_q < WidthW'(2 * ByteW));
	assign status.slot_free = !ovalid_q || out_ready;

	// Pending store and bit count of the item at work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			pcnt_q  <= '0;
			width_q <= '0;
		end else if (cmd.load) begin
			if (in_op == OpFlush) begin
				pend_q  <= '0;
				pcnt_q  <= '0;
				width_q <= (pcnt_q != '0) ? WidthW'(ByteW) : '0;
			end else if (n_sat == '0) begin
				width_q <= '0;
			end else begin
				pend_q  <= put_pend;
				pcnt_q  <= put_width[PcntW-1:0];
				width_q <= put_width;
			end
		end else if (cmd.push_stuff || (cmd.push_data && !status.is_ff)) begin
			width_q <= rem_width;
		end
	end

	// Accumulator contents need no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (in_op == OpFlush) begin
				acc_q <= {{(AccW-ByteW){1'b0}}, flush_byte};
			end else begin
				acc_q <= put_acc;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.push_data || cmd.push_stuff) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (cmd.push_data) begin
			obyte_q <= top_byte;
			olast_q <= !status.is_ff && status.last_byte;
		end else if (cmd.push_stuff) begin
			obyte_q <= StuffByte;
			olast_q <= status.last_byte;
		end
	end

	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign out_last  = olast_q;

endmodule

`default_nettype wire

[rtl/core/bps_checker.sv]
// Port-level checker for the bit packer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bps_checker
	import bps_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OutDataW-1:0] m_tdata,
	input wire logic                m_tlast
);

	logic out_acc;
	logic after_ff_q;

	assign out_acc = m_tvalid && m_tready;

	// Tracks that the last output word taken was the stuffing mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_ff_q <= 1'b0;
		end else if (out_acc) begin
			after_ff_q <= (m_tdata == StuffMark);
		end
	end

	`BPS_ASSERT_NXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid, "output word dropped")
	`BPS_ASSERT_NOW(a_stuff_follows, out_acc && after_ff_q, m_tdata == StuffByte, "no stuffed zero")
	`BPS_ASSERT_NOW(a_ff_not_last, out_acc && m_tdata == StuffMark, !m_tlast, "0xFF marked last")
	`BPS_ASSERT_NXT(a_one_word_in_flight, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

endmodule

bind bit_packer_byte_stuffing bps_checker u_bps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
